// ===== design/ssh_banner_checker_assert.svh =====
`ifndef SSH_BANNER_CHECKER_ASSERT_SVH
`define SSH_BANNER_CHECKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SBC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/ssh_bc_pkg.sv =====
package ssh_bc_pkg;

	localparam int unsigned CountW = 10;
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	localparam logic [CountW-1:0] LIMIT_RESET = 10'd512;
	localparam logic [CountW-1:0] SPACE_MAX   = 10'd1023;
	localparam logic [2:0]        PREFIX_LEN  = 3'd4;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_END  = 1'b1;

	localparam logic KIND_CHAR   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] VERDICT_SSH  = 2'd0;
	localparam logic [1:0] VERDICT_NOT  = 2'd1;
	localparam logic [1:0] VERDICT_NONE = 2'd2;

	localparam logic [7:0] BYTE_CR    = 8'h0d;
	localparam logic [7:0] BYTE_LF    = 8'h0a;
	localparam logic [6:0] CHAR_SPACE = 7'h20;
	localparam logic [6:0] CHAR_QMARK = 7'h3f;

	typedef struct packed {
		logic              kind;
		logic [CountW-1:0] spaces;
		logic [6:0]        chr;
		logic [1:0]        verdict;
	} rec_t;

	function automatic logic [6:0] prefix_char(input logic [1:0] idx);
		logic [6:0] c;
		case (idx)
			2'd0: c = 7'h53;
			2'd1: c = 7'h53;
			2'd2: c = 7'h48;
			default: c = 7'h2d;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] verdict_of(input logic [CountW-1:0] cnt,
			input logic good, input logic [2:0] pos);
		logic [1:0] v;
		if (cnt == '0) begin
			v = VERDICT_NONE;
		end else if (good && (pos >= PREFIX_LEN)) begin
			v = VERDICT_SSH;
		end else begin
			v = VERDICT_NOT;
		end
		return v;
	endfunction

endpackage

// ===== design/ssh_bc_front.sv =====
module ssh_bc_front import ssh_bc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [7:0]        in_byte,
	input  logic              cfg_we,
	input  logic [CountW-1:0] cfg_wdata,
	input  logic              q_full,
	output logic              push,
	output rec_t              push_rec
);

	logic [CountW-1:0] limit_q;
	logic              line_done_q;
	logic [CountW-1:0] raw_count_q;
	logic [CountW-1:0] pending_q;
	logic [2:0]        prefix_pos_q;
	logic              prefix_good_q;

	logic              line_done_n;
	logic [CountW-1:0] raw_count_n;
	logic [CountW-1:0] pending_n;
	logic [2:0]        prefix_pos_n;
	logic              prefix_good_n;
	logic              push_c;
	logic [6:0]        chr;
	logic              acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign chr      = (in_byte inside {[8'h20:8'h7e]}) ? in_byte[6:0] : CHAR_QMARK;

	always_comb begin
		line_done_n   = line_done_q;
		raw_count_n   = raw_count_q;
		pending_n     = pending_q;
		prefix_pos_n  = prefix_pos_q;
		prefix_good_n = prefix_good_q;
		push_c        = 1'b0;
		push_rec      = '0;
		if (func == FUNC_END) begin
			if (!line_done_q) begin
				push_c           = 1'b1;
				push_rec.kind    = KIND_STATUS;
				push_rec.verdict = verdict_of(raw_count_q, prefix_good_q, prefix_pos_q);
			end
			line_done_n   = 1'b0;
			raw_count_n   = '0;
			pending_n     = '0;
			prefix_pos_n  = '0;
			prefix_good_n = 1'b1;
		end else if (!line_done_q) begin
			if (raw_count_q >= limit_q) begin
				line_done_n      = 1'b1;
				push_c           = 1'b1;
				push_rec.kind    = KIND_STATUS;
				push_rec.verdict = verdict_of(raw_count_q, prefix_good_q, prefix_pos_q);
			end else begin
				raw_count_n = raw_count_q + CountW'(1);
				if (in_byte == BYTE_CR || in_byte == BYTE_LF) begin
					line_done_n      = 1'b1;
					push_c           = 1'b1;
					push_rec.kind    = KIND_STATUS;
					push_rec.verdict = verdict_of(raw_count_n, prefix_good_q, prefix_pos_q);
				end else begin
					if (prefix_pos_q < PREFIX_LEN) begin
						if (chr != prefix_char(prefix_pos_q[1:0])) begin
							prefix_good_n = 1'b0;
						end
						prefix_pos_n = prefix_pos_q + 3'd1;
					end
					if (chr == CHAR_SPACE) begin
						if (pending_q < SPACE_MAX) begin
							pending_n = pending_q + CountW'(1);
						end
					end else begin
						push_c          = 1'b1;
						push_rec.kind   = KIND_CHAR;
						push_rec.spaces = pending_q;
						push_rec.chr    = chr;
						pending_n       = '0;
					end
				end
			end
		end
	end

	assign push = acc && push_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_done_q   <= 1'b0;
			raw_count_q   <= '0;
			pending_q     <= '0;
			prefix_pos_q  <= '0;
			prefix_good_q <= 1'b1;
		end else if (acc) begin
			line_done_q   <= line_done_n;
			raw_count_q   <= raw_count_n;
			pending_q     <= pending_n;
			prefix_pos_q  <= prefix_pos_n;
			prefix_good_q <= prefix_good_n;
		end
	end

endmodule

// ===== design/ssh_bc_queue.sv =====
module ssh_bc_queue import ssh_bc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	output logic out_valid,
	input  logic out_ready,
	output rec_t out_rec
);

	rec_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic             pop;

	assign full      = (count_q == QCntW'(QDepth));
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCntW'(1);
				2'b01:   count_q <= count_q - QCntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/ssh_banner_checker.sv =====
// SSH greeting checker: takes one transfer per cycle (a received byte, or an end-of-connection
// item) and answers with at most one result: a printable banner character with the count of
// spaces held back before it, or the final status (ssh detected, not ssh, no banner). A result
// is pushed into the queue as its input transfer is taken. Results wait in a four-entry queue, so
// input keeps flowing while the output side stalls; in_ready falls only when the queue is full. The user
// must write banner_limit (reset 512) via cfg_we/cfg_wdata only while no item is in flight (not enforced).
module ssh_banner_checker import ssh_bc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [7:0]        in_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_kind,
	output logic [CountW-1:0] spaces_before,
	output logic [6:0]        out_char,
	output logic [1:0]        verdict,
	input  logic              cfg_we,
	input  logic [CountW-1:0] cfg_wdata
);

	logic q_full;
	logic push;
	rec_t push_rec;
	rec_t out_rec;

	ssh_bc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.in_byte  (in_byte),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_full   (q_full),
		.push     (push),
		.push_rec (push_rec)
	);

	ssh_bc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_rec  (out_rec)
	);

	assign out_kind      = out_rec.kind;
	assign spaces_before = out_rec.spaces;
	assign out_char      = out_rec.chr;
	assign verdict       = out_rec.verdict;

endmodule

// ===== design/ssh_bc_checker.sv =====
`include "ssh_banner_checker_assert.svh"

module ssh_bc_checker import ssh_bc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              func,
	input logic [7:0]        in_byte,
	input logic              out_valid,
	input logic              out_ready,
	input logic              out_kind,
	input logic [CountW-1:0] spaces_before,
	input logic [6:0]        out_char,
	input logic [1:0]        verdict,
	input logic              cfg_we,
	input logic [CountW-1:0] cfg_wdata
);

	`SBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(spaces_before) && $stable(out_char) && $stable(verdict))
	`SBC_ASSERT_NOW(a_status_clean, out_valid && out_kind == KIND_STATUS, spaces_before == '0 && out_char == '0 && verdict != 2'd3)
	`SBC_ASSERT_NOW(a_char_clean, out_valid && out_kind == KIND_CHAR, out_char >= 7'h21 && out_char <= 7'h7e && verdict == VERDICT_SSH)
	`SBC_ASSERT_NOW(a_stall_has_output, !in_ready, out_valid)

endmodule

bind ssh_banner_checker ssh_bc_checker u_chk (.*);

// ===== verif/ssh_banner_monitor.sv =====
module ssh_banner_monitor import ssh_bc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              func,
	input  logic [7:0]        in_byte,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              out_kind,
	input  logic [CountW-1:0] spaces_before,
	input  logic [6:0]        out_char,
	input  logic [1:0]        verdict,
	input  logic              cfg_we,
	input  logic [CountW-1:0] cfg_wdata,
	output int                mismatches,
	output int                backlog,
	output int                char_count,
	output int                status_count
);

	localparam logic [31:0] SSH_TAG = "SSH-";

	logic              line_over;
	logic [CountW-1:0] byte_total;
	logic [CountW-1:0] space_run;
	logic [CountW-1:0] limit_reg;
	logic [2:0]        tag_pos;
	logic              tag_ok;
	rec_t              predicted_recs[$];

	function automatic logic [1:0] line_verdict();
		if (byte_total == '0)
			return VERDICT_NONE;
		if (tag_ok && tag_pos >= PREFIX_LEN)
			return VERDICT_SSH;
		return VERDICT_NOT;
	endfunction

	task automatic clear_line();
		line_over = 1'b0;
		byte_total = '0;
		space_run = '0;
		tag_pos = '0;
		tag_ok = 1'b1;
	endtask

	task automatic close_line();
		rec_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.verdict = line_verdict();
		predicted_recs = {predicted_recs, r};
	endtask

	task automatic take_byte(input logic [7:0] b);
		rec_t r;
		logic [6:0] c;
		if (line_over)
			return;
		if (byte_total >= limit_reg) begin
			line_over = 1'b1;
			close_line();
			return;
		end
		byte_total = byte_total + CountW'(1);
		if (b == BYTE_CR || b == BYTE_LF) begin
			line_over = 1'b1;
			close_line();
			return;
		end
		c = (b >= 8'h20 && b < 8'h7f) ? b[6:0] : CHAR_QMARK;
		if (tag_pos < PREFIX_LEN) begin
			if (c != SSH_TAG[8 * (3 - int'(tag_pos)) +: 7])
				tag_ok = 1'b0;
			tag_pos = tag_pos + 3'd1;
		end
		if (c == CHAR_SPACE) begin
			if (space_run != SPACE_MAX)
				space_run = space_run + CountW'(1);
			return;
		end
		r = '0;
		r.kind = KIND_CHAR;
		r.spaces = space_run;
		r.chr = c;
		predicted_recs = {predicted_recs, r};
		space_run = '0;
	endtask

	task automatic check_result();
		rec_t want;
		rec_t got;
		got = {out_kind, spaces_before, out_char, verdict};
		if (predicted_recs.size() == 0) begin
			$display("%0t: unexpected result kind=%0d spaces=%0d char=%0h verdict=%0d",
				$time, got.kind, got.spaces, got.chr, got.verdict);
			mismatches++;
			return;
		end
		want = predicted_recs.pop_front();
		if (want.kind == KIND_CHAR)
			char_count++;
		else
			status_count++;
		if (got.kind !== want.kind || got.spaces !== want.spaces ||
				got.chr !== want.chr || got.verdict !== want.verdict) begin
			$display("%0t: mismatch expected kind=%0d spaces=%0d char=%0h verdict=%0d %s",
				$time, want.kind, want.spaces, want.chr, want.verdict,
				$sformatf("actual kind=%0d spaces=%0d char=%0h verdict=%0d",
				got.kind, got.spaces, got.chr, got.verdict));
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			limit_reg = LIMIT_RESET;
			predicted_recs.delete();
			mismatches = 0;
			char_count = 0;
			status_count = 0;
		end else begin
			if (cfg_we)
				limit_reg = cfg_wdata;
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready) begin
				if (func == FUNC_END) begin
					if (!line_over)
						close_line();
					clear_line();
				end else begin
					take_byte(in_byte);
				end
			end
		end
		backlog = predicted_recs.size();
	end

endmodule

// ===== verif/tb.sv =====
module tb;
	import ssh_bc_pkg::*;

	localparam int          WATCHDOG = 5000;
	localparam int          PHASE_ITEMS = 65;
	localparam logic [31:0] SSH_TAG = "SSH-";

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              func;
	logic [7:0]        in_byte;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              out_kind;
	logic [CountW-1:0] spaces_before;
	logic [6:0]        out_char;
	logic [1:0]        verdict;
	logic              cfg_we;
	logic [CountW-1:0] cfg_wdata;

	logic        in_fire = 1'b0;
	logic        out_fire = 1'b0;
	int          idle_cycles = 0;
	int          mismatches;
	int          backlog;
	int          char_count;
	int          status_count;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned sent = 0;

	always #5 clk = ~clk;

	ssh_banner_checker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_kind     (out_kind),
		.spaces_before(spaces_before),
		.out_char     (out_char),
		.verdict      (verdict),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	ssh_banner_monitor u_mon (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_kind     (out_kind),
		.spaces_before(spaces_before),
		.out_char     (out_char),
		.verdict      (verdict),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.backlog      (backlog),
		.char_count   (char_count),
		.status_count (status_count)
	);

	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		out_fire <= out_valid && out_ready;
	end

	always @(posedge clk) begin
		if (in_fire || out_fire)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG) begin
			$display("tb failed");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	task automatic push_item(input logic f, input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		in_byte <= b;
		@(negedge clk);
		while (!in_fire)
			@(negedge clk);
		sent++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_item(FUNC_BYTE, s[i]);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (backlog != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_limit(input logic [CountW-1:0] lim);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_byte();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 8'($urandom_range(33, 126));
		if (roll < 80)
			return {1'b0, CHAR_SPACE};
		if (roll < 85)
			return 8'($urandom_range(0, 31));
		return 8'($urandom_range(127, 255));
	endfunction

	task automatic random_greeting();
		int unsigned shape;
		int unsigned body;
		logic [7:0] b;
		shape = $urandom_range(0, 9);
		if (shape < 6) begin
			for (int k = 0; k < 4; k++) begin
				b = SSH_TAG[8 * (3 - k) +: 8];
				if ($urandom_range(0, 7) == 0)
					b = pick_byte();
				push_item(FUNC_BYTE, b);
			end
		end
		body = $urandom_range(0, 16);
		repeat (body) push_item(FUNC_BYTE, pick_byte());
		if (shape < 8) begin
			push_item(FUNC_BYTE, $urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
			repeat ($urandom_range(0, 2)) push_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
		end
		push_item(FUNC_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input logic [CountW-1:0] lim);
		int unsigned goal;
		set_limit(lim);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		goal = sent + PHASE_ITEMS;
		while (sent < goal)
			random_greeting();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_BYTE;
		in_byte = 8'h00;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		push_item(FUNC_END, 8'hff);
		push_text("SSH-  a ");
		push_item(FUNC_BYTE, BYTE_CR);
		push_text("x");
		push_item(FUNC_END, 8'h00);
		push_item(FUNC_BYTE, BYTE_LF);
		push_item(FUNC_END, 8'h5a);
		push_item(FUNC_BYTE, 8'h00);
		push_item(FUNC_BYTE, 8'h7f);
		push_item(FUNC_BYTE, 8'h80);
		push_item(FUNC_BYTE, 8'hff);
		push_item(FUNC_BYTE, 8'h1f);
		push_item(FUNC_BYTE, 8'h7e);
		push_item(FUNC_BYTE, 8'h20);
		push_item(FUNC_END, 8'ha5);
		push_text("SSH");
		push_item(FUNC_END, 8'h00);

		push_text("SSH-a");
		set_limit(10'd3);
		push_text("b");
		push_item(FUNC_END, 8'h00);
		set_limit(10'd0);
		push_text("S");
		push_item(FUNC_END, 8'h00);
		set_limit(10'd4);
		push_text("SSH-x");
		push_item(FUNC_END, 8'h00);
		set_limit(10'd1023);
		repeat (40) push_item(FUNC_BYTE, {1'b0, CHAR_SPACE});
		push_text("xy");
		push_item(FUNC_END, 8'h00);

		run_phase(0, 0, 10'd512);
		run_phase(82, 0, 10'($urandom_range(1, 40)));
		run_phase(0, 82, 10'd1023);
		run_phase(7, 7, 10'($urandom_range(5, 20)));
		run_phase(0, 0, 10'd1);
		run_phase(7, 7, 10'd512);

		settle();
		repeat (4) @(negedge clk);
		$display("covered %0d input transfers, %0d banner characters, %0d status results",
			sent, char_count, status_count);
		$display("limits from 0 to 1023, with sender and receiver pacing varied per phase");
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/ssh_bc_pkg.sv
design/ssh_bc_front.sv
design/ssh_bc_queue.sv
design/ssh_banner_checker.sv
design/ssh_bc_checker.sv
verif/ssh_banner_monitor.sv
verif/tb.sv
